### hdl/dcsl_pkg.sv
// Package for the DC motor speed loop: request and result types, register
// indexes, reset values and the widths shared by the serial arithmetic units.
// No dependencies.
`timescale 1ns / 1ps
package dcsl_pkg;

  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DVD_W  = 20;
  localparam int unsigned DVS_W  = 10;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_W);
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [MUL_W-1:0] SPEED_NUM  = MUL_W'(10);
  localparam logic [DVS_W-1:0] SPEED_DEN  = DVS_W'(11);
  localparam logic [DVS_W-1:0] ADC_FULL   = DVS_W'(1023);
  localparam logic [9:0]       ACC_MAX    = 10'd1023;

  localparam logic [15:0] GAIN_RST     = 16'd786;
  localparam logic [9:0]  MAX_RPM_RST  = 10'd330;
  localparam logic [9:0]  FULL_SC_RST  = 10'd1000;
  localparam logic [15:0] LOW_LIM_RST  = 16'd50;
  localparam logic [15:0] MID_LIM_RST  = 16'd300;

  typedef enum logic [2:0] {
    CFG_GAIN     = 3'd0,
    CFG_MAX_RPM  = 3'd1,
    CFG_FULL_SC  = 3'd2,
    CFG_LOW_LIM  = 3'd3,
    CFG_MID_LIM  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_e;

  typedef struct packed {
    logic [9:0]  adc_sample;
    logic [15:0] pulse_count;
    logic        dir_toggle;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  duty_forward;
    logic [9:0]  duty_reverse;
    logic        direction;
    logic [9:0]  setpoint_rpm;
    logic [15:0] measured_rpm;
    logic [1:0]  speed_band;
  } out_req_t;

endpackage

### hdl/dcsl_ser_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on dcsl_pkg.
`timescale 1ns / 1ps
module dcsl_ser_mul import dcsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0]    p_q;
  logic [MUL_W-1:0]     a_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [MUL_W:0]       sum;

  assign sum = {1'b0, p_q[PROD_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{MUL_W{1'b0}}, b_i};
      a_q <= a_i;
    end else if (busy_q) begin
      p_q <= {sum, p_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

### hdl/dcsl_ser_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dcsl_pkg.
`timescale 1ns / 1ps
module dcsl_ser_div import dcsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  logic [DVS_W-1:0]     rem_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hdl/dc_motor_speed_loop_unit.sv
// Top level of the DC motor speed loop: configuration registers, sequencer,
// controller state and result register. Depends on dcsl_pkg, dcsl_ser_mul
// and dcsl_ser_div.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   in       | in_valid_i, in_ready_o, in_data_i | request in
//   out      | out_valid_o, out_ready_i, out_data_o | result out
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i   | register write
//
// Each request takes six or seven passes through the shared bit-serial
// multiplier (16 steps) and divider (20 steps).
// Reset clears the duty accumulator, selects forward and loads the register
// defaults. A new request is taken once the previous one is in the result
// register; a stalled result only holds the sequencer at its final step.
`timescale 1ns / 1ps
module dc_motor_speed_loop_unit import dcsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_req_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_MEAS_MUL = 9'b000000010,
    S_MEAS_DIV = 9'b000000100,
    S_SP_MUL   = 9'b000001000,
    S_SP_DIV   = 9'b000010000,
    S_ERR_MUL  = 9'b000100000,
    S_DUTY_MUL = 9'b001000000,
    S_DUTY_DIV = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   go_q, go_d;

  logic [15:0] gain_q;
  logic [9:0]  max_rpm_q;
  logic [9:0]  full_sc_q;
  logic [15:0] low_lim_q;
  logic [15:0] mid_lim_q;

  logic [9:0]  acc_q, acc_d;
  logic        rev_q;
  logic [9:0]  adc_q;
  logic [15:0] pulses_q;
  logic [15:0] meas_q;
  logic [9:0]  sp_q;
  logic [9:0]  duty_q;

  logic        out_valid_q;
  out_req_t    out_q;

  logic               mul_start, mul_done;
  logic               div_start, div_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_quo;

  logic [15:0] sp_ext;
  logic [15:0] err_mag;
  logic        sp_gt;
  logic [24:0] up_sum;
  logic [31:0] acc_shift;
  logic [31:0] down_diff;
  logic [9:0]  acc_upd;
  logic [1:0]  band;
  logic        out_free;

  assign sp_ext  = {6'd0, sp_q};
  assign sp_gt   = sp_ext > meas_q;
  assign err_mag = sp_gt ? (sp_ext - meas_q) : (meas_q - sp_ext);

  assign up_sum    = {15'd0, acc_q} + {1'b0, mul_prod[PROD_W-1:8]};
  assign acc_shift = {14'd0, acc_q, 8'd0};
  assign down_diff = acc_shift - mul_prod;

  always_comb begin
    if (sp_gt) begin
      acc_upd = (up_sum > {15'd0, ACC_MAX}) ? ACC_MAX : up_sum[9:0];
    end else if (mul_prod > acc_shift) begin
      acc_upd = '0;
    end else begin
      acc_upd = down_diff[17:8];
    end
    if (sp_q == '0) begin
      acc_upd = '0;
    end
  end

  always_comb begin
    if (meas_q <= low_lim_q) begin
      band = BAND_LOW;
    end else if (meas_q <= mid_lim_q) begin
      band = BAND_MID;
    end else begin
      band = BAND_HIGH;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MEAS_MUL: begin
        mul_a = pulses_q;
        mul_b = SPEED_NUM;
      end
      S_SP_MUL: begin
        mul_a = {6'd0, adc_q};
        mul_b = {6'd0, max_rpm_q};
      end
      S_ERR_MUL: begin
        mul_a = gain_q;
        mul_b = err_mag;
      end
      S_DUTY_MUL: begin
        mul_a = {6'd0, acc_q};
        mul_b = {6'd0, full_sc_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_dvs = (state_q == S_MEAS_DIV) ? SPEED_DEN : ADC_FULL;

  assign mul_start = go_q && (state_q == S_MEAS_MUL || state_q == S_SP_MUL ||
                              state_q == S_ERR_MUL || state_q == S_DUTY_MUL);
  assign div_start = go_q && (state_q == S_MEAS_DIV || state_q == S_SP_DIV ||
                              state_q == S_DUTY_DIV);

  dcsl_ser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  dcsl_ser_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod[DVD_W-1:0]),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MEAS_MUL;
          go_d    = 1'b1;
        end
      end
      S_MEAS_MUL: begin
        if (mul_done) begin
          state_d = S_MEAS_DIV;
          go_d    = 1'b1;
        end
      end
      S_MEAS_DIV: begin
        if (div_done) begin
          state_d = S_SP_MUL;
          go_d    = 1'b1;
        end
      end
      S_SP_MUL: begin
        if (mul_done) begin
          state_d = S_SP_DIV;
          go_d    = 1'b1;
        end
      end
      S_SP_DIV: begin
        if (div_done) begin
          state_d = ({6'd0, div_quo[9:0]} != meas_q) ? S_ERR_MUL : S_DUTY_MUL;
          go_d    = 1'b1;
        end
      end
      S_ERR_MUL: begin
        if (mul_done) begin
          acc_d   = acc_upd;
          state_d = S_DUTY_MUL;
          go_d    = 1'b1;
        end
      end
      S_DUTY_MUL: begin
        if (mul_done) begin
          state_d = S_DUTY_DIV;
          go_d    = 1'b1;
        end
      end
      S_DUTY_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      acc_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      acc_q   <= acc_d;
      if (in_valid_i && in_ready_o && in_data_i.dir_toggle) begin
        rev_q <= !rev_q;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RST;
      max_rpm_q <= MAX_RPM_RST;
      full_sc_q <= FULL_SC_RST;
      low_lim_q <= LOW_LIM_RST;
      mid_lim_q <= MID_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:    gain_q    <= cfg_data_i;
        CFG_MAX_RPM: max_rpm_q <= cfg_data_i[9:0];
        CFG_FULL_SC: full_sc_q <= cfg_data_i[9:0];
        CFG_LOW_LIM: low_lim_q <= cfg_data_i;
        CFG_MID_LIM: mid_lim_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      adc_q    <= in_data_i.adc_sample;
      pulses_q <= in_data_i.pulse_count;
    end
    if (state_q == S_MEAS_DIV && div_done) begin
      meas_q <= div_quo[15:0];
    end
    if (state_q == S_SP_DIV && div_done) begin
      sp_q <= div_quo[9:0];
    end
    if (state_q == S_DUTY_DIV && div_done) begin
      duty_q <= div_quo[9:0];
    end
    if (state_q == S_OUT && out_free) begin
      out_q.duty_forward <= rev_q ? 10'd0 : duty_q;
      out_q.duty_reverse <= rev_q ? duty_q : 10'd0;
      out_q.direction    <= rev_q;
      out_q.setpoint_rpm <= sp_q;
      out_q.measured_rpm <= meas_q;
      out_q.speed_band   <= band;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
